// ===== sv/crr_pkg.sv =====
// ----------------------------------------------------------------------------
// crr_pkg
// Shared constants and state types of the Catmull-Rom resampler.
// ----------------------------------------------------------------------------
package crr_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int FRAME_W         = 24;
    localparam int POS_W           = FRAME_W + FRAC_BITS;
    localparam int MAX_CHANNELS    = 8;
    localparam int CH_W            = 3;
    localparam int HIST_FRAMES     = 4;
    localparam int SLOT_W          = 2;
    localparam int ADDR_W          = SLOT_W + CH_W;
    localparam int DEPTH           = HIST_FRAMES * MAX_CHANNELS;
    localparam int MAX_RESULTS     = 64;
    localparam int N_W             = 7;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int GUARD_BITS      = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT   = 2'd2;

    localparam logic [3:0]         RST_CHANNELS = 4'd1;
    localparam logic [CFG_W-1:0]   RST_RATIO    = 32'h0100_0000;
    localparam logic [FRAME_W-1:0] RST_LIMIT    = 24'hFF_FFFF;
    localparam logic [CFG_W-1:0]   MIN_RATIO    = 32'h0040_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HPUT,
        ST_RD,
        ST_CALC,
        ST_PUT,
        ST_STAT
    } t_state;

    typedef enum logic [2:0] {
        CU_IDLE,
        CU_COEF,
        CU_MUL,
        CU_ADD,
        CU_FIN
    } t_cu_state;

endpackage

// ===== sv/crr_cubic.sv =====
// ----------------------------------------------------------------------------
// crr_cubic
// Sequential Catmull-Rom evaluator: one shared multiplier, Horner form.
// ----------------------------------------------------------------------------
module crr_cubic import crr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_p0,
    input  logic signed [SAMPLE_BITS-1:0] i_p1,
    input  logic signed [SAMPLE_BITS-1:0] i_p2,
    input  logic signed [SAMPLE_BITS-1:0] i_p3,
    input  logic        [FRAC_BITS-1:0]   i_t,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_y
);

    localparam int W  = SAMPLE_BITS + GUARD_BITS;
    localparam int PW = W + FRAC_BITS + 1;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    t_cu_state r_state, n_state;
    logic signed [W-1:0]  r_a, r_b, r_c, r_x;
    logic signed [PW-1:0] r_prod;
    logic [1:0]           r_step;

    logic signed [W-1:0]  e0, e1, e2, e3, coef, sum, y_full;
    logic signed [PW-1:0] rnd;

    assign e0 = W'(i_p0);
    assign e1 = W'(i_p1);
    assign e2 = W'(i_p2);
    assign e3 = W'(i_p3);

    always_comb begin
        case (r_step)
            2'd0:    coef = r_c;
            2'd1:    coef = r_b;
            default: coef = r_a;
        endcase
        rnd    = (r_prod + HALF) >>> FRAC_BITS;
        sum    = coef + rnd[W-1:0];
        y_full = (r_x + W'(1)) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            CU_IDLE: if (i_start) n_state = CU_COEF;
            CU_COEF: n_state = CU_MUL;
            CU_MUL:  n_state = CU_ADD;
            CU_ADD:  n_state = (r_step == 2'd2) ? CU_FIN : CU_MUL;
            CU_FIN:  n_state = CU_IDLE;
            default: n_state = CU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CU_COEF: begin
                r_a    <= e1 <<< 1;
                r_b    <= e2 - e0;
                r_c    <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
                r_x    <= ((e1 - e2) <<< 1) + (e1 - e2) + e3 - e0;
                r_step <= 2'd0;
            end
            CU_MUL: r_prod <= r_x * $signed({1'b0, i_t});
            CU_ADD: begin
                r_x    <= sum;
                r_step <= r_step + 2'd1;
            end
            default: ;
        endcase
    end

    // saturate when the bits above the sample do not all match its sign
    always_comb begin
        if (y_full[W-1:SAMPLE_BITS-1] == '0 || y_full[W-1:SAMPLE_BITS-1] == '1) begin
            o_y = y_full[SAMPLE_BITS-1:0];
        end else begin
            o_y = y_full[W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                              : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign o_done = (r_state == CU_FIN);

endmodule

// ===== sv/catmull_rom_resampler_top.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_resampler_top
// Streaming Catmull-Rom resampler for interleaved audio.
// ----------------------------------------------------------------------------
// A sample that does not complete a frame is taken in ST_IDLE without blocking
// the input. A completing sample blocks the input until all output frames due
// are delivered: after a position check, each output sample reads the four
// taps from the history memory, passes through the shared multiply-add unit
// and is loaded into the output register, and the last sample of a frame is
// held over the next position check. An end of source adds a status beat, and
// all of this takes longer when the output side stalls.
module catmull_rom_resampler_top import crr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_end_of_source,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic [CH_W-1:0]               o_channel_index,
    output logic                          o_run_last,
    output logic                          o_no_sample,
    output logic                          o_source_done,
    output logic [FRAME_W-1:0]            o_frames_written
);

    t_state r_state, n_state;

    logic [3:0]         r_chan_cfg;
    logic [CFG_W-1:0]   r_ratio;
    logic [FRAME_W-1:0] r_limit;

    logic [POS_W-1:0]   r_pos;
    logic [FRAME_W-1:0] r_frames, r_count, r_newest;
    logic [CH_W-1:0]    r_cnt, r_c;
    logic [N_W-1:0]     r_n;
    logic [2:0]         r_k;
    logic [SLOT_W-1:0]  r_tap [HIST_FRAMES];
    logic signed [SAMPLE_BITS-1:0] r_p [HIST_FRAMES];
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic               r_last, r_held, r_go;

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic               r_rd_vld;

    logic [3:0]         ch_eff;
    logic [CFG_W-1:0]   ratio_eff;
    logic               accept, completes, slot_free, go_on, ch_last, cu_start, cu_done;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [FRAME_W-1:0] base, diff, low;
    logic [SLOT_W-1:0]  tap_next [HIST_FRAMES];
    logic [7:0]         room;
    logic signed [SAMPLE_BITS-1:0] cu_y;

    assign ch_eff    = (r_chan_cfg == 4'd0) ? 4'd1 :
                       (r_chan_cfg > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : r_chan_cfg;
    assign ratio_eff = (r_ratio < MIN_RATIO) ? MIN_RATIO : r_ratio;
    assign accept    = i_in_valid && o_in_ready;
    assign completes = i_end_of_source || !((4'(r_cnt) + 4'd1) < ch_eff);
    assign wr_addr   = {r_frames[SLOT_W-1:0], r_cnt};
    assign rd_addr   = {r_tap[r_k[1:0]], r_c};
    assign slot_free = !o_out_valid || i_out_ready;
    assign ch_last   = (4'(r_c) + 4'd1) == ch_eff;

    // position test and tap slots for the next output frame
    always_comb begin
        logic [FRAME_W-1:0] f, ahead;
        base = r_pos[POS_W-1:FRAC_BITS];
        diff = r_newest - base;
        low  = r_last ? '0 : FRAME_W'(2);
        room = 8'(r_n) + 8'(ch_eff) + (r_last ? 8'd1 : 8'd0);
        go_on = !(diff < low || diff[FRAME_W-1]) && (r_count < r_limit)
                && (room <= 8'(MAX_RESULTS));
        for (int k = 0; k < HIST_FRAMES; k++) begin
            f = base + FRAME_W'(k) - FRAME_W'(1);
            if (k == 0 && base == '0) f = '0;
            ahead = f - r_newest;
            if (ahead >= FRAME_W'(1) && ahead <= FRAME_W'(3)) f = r_newest;
            tap_next[k] = f[SLOT_W-1:0];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cfg <= RST_CHANNELS;
            r_ratio    <= RST_RATIO;
            r_limit    <= RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHANNEL_COUNT: r_chan_cfg <= i_cfg_data[3:0];
                REG_STEP_RATIO:    r_ratio    <= i_cfg_data;
                REG_FRAME_LIMIT:   r_limit    <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (accept) r_mem[wr_addr] <= i_sample_in;
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_state == ST_STAT && slot_free) begin
            r_valid <= '0;
        end else if (accept) begin
            r_valid[wr_addr] <= 1'b1;
            // drop the channels an early end never delivered
            if (i_end_of_source) begin
                for (int j = 0; j < MAX_CHANNELS; j++) begin
                    if (CH_W'(j) > r_cnt) r_valid[{r_frames[SLOT_W-1:0], CH_W'(j)}] <= 1'b0;
                end
            end
        end
    end

    crr_cubic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cu_start),
        .i_p0    (r_p[0]),
        .i_p1    (r_p[1]),
        .i_p2    (r_p[2]),
        .i_p3    (r_p[3]),
        .i_t     (r_pos[FRAC_BITS-1:0]),
        .o_done  (cu_done),
        .o_y     (cu_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        cu_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept && completes) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_held)     n_state = ST_HPUT;
                else if (go_on) n_state = ST_RD;
                else if (r_last) n_state = ST_STAT;
                else            n_state = ST_IDLE;
            end
            ST_HPUT: begin
                if (slot_free) begin
                    if (r_go)        n_state = ST_RD;
                    else if (r_last) n_state = ST_STAT;
                    else             n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                if (r_k == 3'd4) begin
                    cu_start = 1'b1;
                    n_state  = ST_CALC;
                end
            end
            ST_CALC: if (cu_done) n_state = ch_last ? ST_CHECK : ST_PUT;
            ST_PUT:  if (slot_free) n_state = ST_RD;
            ST_STAT: if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // stream state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_frames <= '0;
            r_count  <= '0;
            r_cnt    <= '0;
            r_n      <= '0;
            r_held   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (completes) begin
                            r_cnt    <= '0;
                            r_frames <= r_frames + FRAME_W'(1);
                            r_newest <= r_frames;
                            r_last   <= i_end_of_source;
                            r_n      <= '0;
                        end else begin
                            r_cnt <= r_cnt + CH_W'(1);
                        end
                    end
                end
                ST_CHECK: begin
                    r_go <= go_on;
                    r_k  <= '0;
                    if (!r_held) r_c <= '0;
                    for (int k = 0; k < HIST_FRAMES; k++) r_tap[k] <= tap_next[k];
                end
                ST_HPUT: begin
                    if (slot_free) begin
                        r_held <= 1'b0;
                        r_c    <= '0;
                    end
                end
                ST_RD: begin
                    if (r_k != 3'd0) r_p[r_k[1:0] - 2'd1] <= r_rd_vld ? r_rd_data : '0;
                    if (r_k != 3'd4) r_k <= r_k + 3'd1;
                end
                ST_CALC: begin
                    if (cu_done) begin
                        r_y <= cu_y;
                        r_n <= r_n + N_W'(1);
                        if (ch_last) begin
                            // hold the frame's last result until the next check
                            r_held  <= 1'b1;
                            r_count <= r_count + FRAME_W'(1);
                            r_pos   <= r_pos + POS_W'(ratio_eff);
                        end
                    end
                end
                ST_PUT: begin
                    if (slot_free) begin
                        r_c <= r_c + CH_W'(1);
                        r_k <= '0;
                    end
                end
                ST_STAT: begin
                    if (slot_free) begin
                        r_pos    <= '0;
                        r_frames <= '0;
                        r_count  <= '0;
                        r_cnt    <= '0;
                        r_last   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (slot_free && (r_state == ST_PUT || r_state == ST_HPUT
                                   || r_state == ST_STAT)) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_state == ST_PUT || r_state == ST_HPUT) begin
                o_sample_out     <= r_y;
                o_channel_index  <= r_c;
                o_run_last       <= (r_state == ST_HPUT) && !r_go && !r_last;
                o_no_sample      <= 1'b0;
                o_source_done    <= 1'b0;
                o_frames_written <= '0;
            end else if (r_state == ST_STAT) begin
                o_sample_out     <= '0;
                o_channel_index  <= '0;
                o_run_last       <= 1'b1;
                o_no_sample      <= 1'b1;
                o_source_done    <= 1'b1;
                o_frames_written <= r_count;
            end
        end
    end

`ifndef SYNTH
    a_status_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_source_done |-> o_no_sample && o_run_last)
        else $error("status beat without its flags");
    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_W'(MAX_RESULTS))
        else $error("result count past capacity");
    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STAT && slot_free |=> r_frames == '0 && r_pos == '0 && r_valid == '0)
        else $error("stream state not cleared after status");
    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cu_start |=> !o_in_ready)
        else $error("input open while computing");
`endif

endmodule

// ===== bench/tb_catmull_rom_resampler_top.sv =====
// ----------------------------------------------------------------------------
// tb_catmull_rom_resampler_top
// Self-checking bench for the Catmull-Rom resampler: interleaved streams go in
// under random handshake gaps, every output beat is checked against a local
// fixed-point model of history, read position, edge clamps and capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class resample_scoreboard;

    typedef struct {
        logic signed [23:0] smp;
        logic [2:0]         chn;
        bit                 last;
        bit                 nos;
        bit                 done;
        logic [23:0]        fw;
    } t_out_beat;

    t_out_beat   due_beats[$];
    int unsigned chan_reg;
    bit [31:0]   ratio_reg;
    bit [23:0]   limit_reg;
    longint      hist[32];
    bit [47:0]   rd_pos;
    bit [23:0]   frames_in;
    int unsigned chan_ctr;
    bit [23:0]   frames_out;
    int          mismatches;
    int          checked;
    int          accepted;

    function new();
        chan_reg  = 1;
        ratio_reg = 32'h0100_0000;
        limit_reg = 24'hFF_FFFF;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (hist[i]) hist[i] = 0;
        rd_pos     = '0;
        frames_in  = '0;
        chan_ctr   = 0;
        frames_out = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            crr_pkg::REG_CHANNEL_COUNT: chan_reg = val[3:0];
            crr_pkg::REG_STEP_RATIO:    ratio_reg = val;
            crr_pkg::REG_FRAME_LIMIT:   limit_reg = val[23:0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_chans();
        if (chan_reg == 0) return 1;
        if (chan_reg > 8) return 8;
        return chan_reg;
    endfunction

    function longint rnd_frac(longint x);
        return (x + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function logic [23:0] cubic(longint p0, longint p1, longint p2, longint p3,
                                longint t);
        longint a, b, c, d, s, y;
        a = 2 * p1;
        b = p2 - p0;
        c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d = -p0 + 3 * p1 - 3 * p2 + p3;
        s = c + rnd_frac(t * d);
        s = b + rnd_frac(t * s);
        s = a + rnd_frac(t * s);
        y = (s + 1) >>> 1;
        if (y > 64'sd8388607) y = 64'sd8388607;
        if (y < -64'sd8388608) y = -64'sd8388608;
        return y[23:0];
    endfunction

    function bit [23:0] tap_frame(bit [23:0] base, int k, bit [23:0] newest);
        bit [23:0] f, ahead;
        f = base + k[23:0] - 24'd1;
        if (k == 0 && base == 0) f = '0;
        ahead = f - newest;
        if (ahead >= 1 && ahead <= 3) f = newest;
        return f;
    endfunction

    // Note an accepted input beat and queue the output beats it causes.
    function void take_sample(logic signed [23:0] smp, bit eos);
        int unsigned ch, cur, slot, n, reserve;
        bit [23:0]   newest, low, base, diff;
        bit [31:0]   rat;
        longint      t;
        int          s[4];
        t_out_beat   ob;
        accepted++;
        ch   = eff_chans();
        cur  = chan_ctr & 7;
        slot = frames_in % 4;
        rat  = (ratio_reg < 32'h0040_0000) ? 32'h0040_0000 : ratio_reg;
        reserve = eos ? 1 : 0;
        n = 0;
        hist[slot * 8 + cur] = smp;
        if (!eos && cur + 1 < ch) begin
            chan_ctr = cur + 1;
            return;
        end
        if (eos)
            for (int c = cur + 1; c < 8; c++) hist[slot * 8 + c] = 0;
        chan_ctr  = 0;
        frames_in = frames_in + 24'd1;
        newest    = frames_in - 24'd1;
        low       = eos ? 24'd0 : 24'd2;
        forever begin
            base = rd_pos[47:24];
            diff = newest - base;
            t    = longint'(rd_pos[23:0]);
            if (diff < low || diff >= 24'h80_0000) break;
            if (frames_out >= limit_reg) break;
            if (n + ch + reserve > 64) break;
            for (int k = 0; k < 4; k++) s[k] = (tap_frame(base, k, newest) % 4) * 8;
            for (int c = 0; c < ch; c++) begin
                ob.smp  = cubic(hist[s[0] + c], hist[s[1] + c], hist[s[2] + c],
                                hist[s[3] + c], t);
                ob.chn  = c[2:0];
                ob.last = 0;
                ob.nos  = 0;
                ob.done = 0;
                ob.fw   = '0;
                due_beats.push_back(ob);
                n++;
            end
            frames_out = frames_out + 24'd1;
            rd_pos     = rd_pos + {16'd0, rat};
        end
        if (eos) begin
            ob.smp  = '0;
            ob.chn  = '0;
            ob.last = 1;
            ob.nos  = 1;
            ob.done = 1;
            ob.fw   = frames_out;
            due_beats.push_back(ob);
            clear_stream();
        end else if (n > 0) begin
            due_beats[due_beats.size() - 1].last = 1;
        end
    endfunction

    function void check_output(logic signed [23:0] smp, logic [2:0] chn, bit last,
                               bit nos, bit done, logic [23:0] fw);
        t_out_beat e;
        checked++;
        if (due_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output beat: sample %0d ch %0d", smp, chn);
            return;
        end
        e = due_beats.pop_front();
        if (e.smp !== smp || e.chn !== chn || e.last !== last || e.nos !== nos ||
            e.done !== done || e.fw !== fw) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"beat %0d mismatch: exp smp %0d ch %0d last %0d nos %0d",
                          " done %0d fw %0d / got smp %0d ch %0d last %0d nos %0d",
                          " done %0d fw %0d"}, checked, e.smp, e.chn, e.last,
                         e.nos, e.done, e.fw, smp, chn, last, nos, done, fw);
        end
    endfunction

endclass

module tb_catmull_rom_resampler_top;
    import crr_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int ITEM_TARGET = 320;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [23:0]   i_sample_in;
    logic                 i_end_of_source;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [23:0]   o_sample_out;
    logic [CH_W-1:0]      o_channel_index;
    logic                 o_run_last;
    logic                 o_no_sample;
    logic                 o_source_done;
    logic [FRAME_W-1:0]   o_frames_written;

    resample_scoreboard sb;
    int  cycles;
    int  streams;
    bit  burst;
    bit  held;

    catmull_rom_resampler_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_in     (i_sample_in),
        .i_end_of_source (i_end_of_source),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_out    (o_sample_out),
        .o_channel_index (o_channel_index),
        .o_run_last      (o_run_last),
        .o_no_sample     (o_no_sample),
        .o_source_done   (o_source_done),
        .o_frames_written(o_frames_written)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.take_sample(i_sample_in, i_end_of_source);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_output(o_sample_out, o_channel_index, o_run_last, o_no_sample,
                            o_source_done, o_frames_written);
    end

    // Receiver: random gaps per beat, one long hold once the run is under way.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 4);
            if (!held && sb.checked >= 150) begin
                held = 1;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_beat(logic signed [23:0] smp, bit eos);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample_in     <= smp;
        i_end_of_source <= eos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Hold the input off until every due beat is out, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_beats.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000;
            1: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    // One stream of whole frames; end it normally, early, or not at all.
    task automatic send_stream(int frames);
        int ch, mode, cut;
        ch   = sb.eff_chans();
        mode = $urandom_range(0, 9);
        cut  = $urandom_range(0, ch - 1);
        streams++;
        for (int f = 0; f < frames; f++)
            for (int c = 0; c < ch; c++) begin
                if (f == frames - 1 && mode == 0 && c == cut) begin
                    send_beat(pick_sample(), 1'b1);
                    return;
                end
                if (f == frames - 1 && c == ch - 1) begin
                    send_beat(pick_sample(), mode != 1);
                    return;
                end
                send_beat(pick_sample(), 1'b0);
            end
    endtask

    initial begin
        logic [31:0] rat;
        sb = new();
        cycles = 0;
        streams = 0;
        burst = 0;
        held = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_CHANNEL_COUNT;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_sample_in     <= '0;
        i_end_of_source <= 1'b0;
        i_out_ready     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes at reset settings, unit ratio
        send_beat(24'sh7F_FFFF, 0);
        send_beat(24'sh80_0000, 0);
        send_beat(24'sh7F_FFFF, 0);
        send_beat(24'sh55_5555, 0);
        send_beat(24'shAA_AAAA, 0);
        send_beat(24'sd0, 1);
        drain();
        // zero ratio acts as the minimum, early end of a three-channel frame
        reg_write(REG_CHANNEL_COUNT, 32'd3);
        reg_write(REG_STEP_RATIO, 32'd0);
        for (int i = 0; i < 7; i++) send_beat(pick_sample(), i == 6);
        drain();
        // counter past count: shrink the channel count mid-frame
        reg_write(REG_CHANNEL_COUNT, 32'd4);
        reg_write(REG_STEP_RATIO, 32'h0080_0000);
        send_beat(24'sd100, 0);
        send_beat(24'sd200, 0);
        send_beat(24'sd300, 0);
        drain();
        reg_write(REG_CHANNEL_COUNT, 32'd2);
        send_beat(24'sd400, 0);
        send_beat(-24'sd5, 1);
        drain();
        // zero capacity, then channel count of zero and of fifteen
        reg_write(REG_FRAME_LIMIT, 32'd0);
        reg_write(REG_CHANNEL_COUNT, 32'd0);
        send_beat(24'sd7, 0);
        send_beat(24'sd9, 1);
        drain();
        reg_write(REG_FRAME_LIMIT, 32'h00FF_FFFF);
        reg_write(REG_CHANNEL_COUNT, 32'd15);
        reg_write(REG_STEP_RATIO, 32'hFFFF_FFFF);
        send_stream(1);
        drain();

        for (int ph = 0; sb.accepted < ITEM_TARGET + 1; ph++) begin
            burst = (ph % 4 == 3);
            reg_write(REG_CHANNEL_COUNT, $urandom_range(0, 5) == 0 ?
                      $urandom_range(0, 15) : $urandom_range(1, 8));
            case ($urandom_range(0, 5))
                0: rat = $urandom_range(0, 32'h003F_FFFF);
                1: rat = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0040_0000;
                2: rat = 32'h0100_0000;
                default: rat = $urandom_range(32'h0040_0000, 32'h0400_0000);
            endcase
            reg_write(REG_STEP_RATIO, rat);
            reg_write(REG_FRAME_LIMIT, $urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 20) : 32'h00FF_FFFF);
            for (int k = 0; k < 3 && sb.accepted < ITEM_TARGET + 1; k++)
                send_stream($urandom_range(1, 8));
            drain();
        end
        burst = 0;
        drain();

        $display("%0d input beats in %0d streams, %0d output beats checked",
                 sb.accepted, streams, sb.checked);
        $display("settings swept: 0..15 channels, ratios 0..max, limits 0..max");
        if (sb.mismatches == 0 && sb.due_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d beats missing", sb.mismatches,
                     sb.due_beats.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
